// File: rtl/core/thrt_pkg.sv
// Shared constants and the resistance table for the thermistor converter.
package thrt_pkg;

    localparam int TABLE_ENTRIES = 121;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int RES_W         = 18;
    localparam int TEMP_W        = 14;
    localparam int S_DATA_W      = ((RES_W + 7) / 8) * 8;
    localparam int M_DATA_W      = ((TEMP_W + 7) / 8) * 8;

    // Ten equal sub-steps per degree; each one is a tenth of a degree.
    localparam int SUB_STEPS     = 10;
    localparam int K_W           = $clog2(SUB_STEPS + 1);
    localparam int HUNDREDTHS    = 100;

    // x / 10 == (x * RECIP) >> RECIP_SHIFT holds exactly for every 18-bit x.
    localparam int RECIP_SHIFT   = 21;
    localparam logic [RES_W-1:0] RECIP = RES_W'(((1 << RECIP_SHIFT) + 9) / 10);
    localparam int PROD_W        = 2 * RES_W;
    localparam int STEP_W        = PROD_W - RECIP_SHIFT;

    // Descending resistance in ohms; entry i stands for i degrees Celsius.
    localparam logic [RES_W-1:0] ROM_RES [TABLE_ENTRIES] = '{
        18'd220859, 18'd220186, 18'd219486, 18'd218758, 18'd218001, 18'd217214,
        18'd216397, 18'd215549, 18'd214669, 18'd213758, 18'd212814, 18'd211836,
        18'd210825, 18'd209779, 18'd208698, 18'd207583, 18'd206431, 18'd205243,
        18'd204019, 18'd202757, 18'd201459, 18'd200124, 18'd198751, 18'd197340,
        18'd195892, 18'd194406, 18'd192882, 18'd191321, 18'd189723, 18'd188088,
        18'd186415, 18'd184707, 18'd182962, 18'd181181, 18'd179366, 18'd177516,
        18'd175632, 18'd173716, 18'd171767, 18'd169786, 18'd167775, 18'd165735,
        18'd163666, 18'd161570, 18'd159447, 18'd157299, 18'd155128, 18'd152933,
        18'd150718, 18'd148482, 18'd146228, 18'd143957, 18'd141670, 18'd139369,
        18'd137055, 18'd134729, 18'd132394, 18'd130051, 18'd127701, 18'd125345,
        18'd122986, 18'd120624, 18'd118262, 18'd115900, 18'd113540, 18'd111184,
        18'd108833, 18'd106489, 18'd104152, 18'd101823, 18'd99506,  18'd97199,
        18'd94906,  18'd92626,  18'd90361,  18'd88112,  18'd85880,  18'd83667,
        18'd81472,  18'd79297,  18'd77142,  18'd75009,  18'd72898,  18'd70810,
        18'd68746,  18'd66705,  18'd64689,  18'd62698,  18'd60733,  18'd58793,
        18'd56880,  18'd54993,  18'd53133,  18'd51301,  18'd49495,  18'd47717,
        18'd45967,  18'd44244,  18'd42549,  18'd40882,  18'd39243,  18'd37631,
        18'd36046,  18'd34490,  18'd32960,  18'd31458,  18'd29983,  18'd28535,
        18'd27114,  18'd25719,  18'd24351,  18'd23008,  18'd21691,  18'd20400,
        18'd19134,  18'd17892,  18'd16676,  18'd15483,  18'd14315,  18'd13170,
        18'd12048
    };

    // Table read; an index past the last entry reads as zero.
    function automatic logic [RES_W-1:0] rom_res(input logic [IDX_W-1:0] idx);
        logic [RES_W-1:0] val;
        val = '0;
        if (int'(idx) < TABLE_ENTRIES) begin
            val = ROM_RES[idx];
        end
        return val;
    endfunction

endpackage

// File: rtl/core/thermistor_resistance_to_temp.sv
// Thermistor resistance to temperature converter: table walk and sub-step interpolation.
// A reading outside the table goes straight to the output register; else the table walk reads
// one ROM entry per cycle (at most TABLE_ENTRIES - 1), and a reading between entries then takes
// one step multiply, one sub-step set-up and up to ten sub-step compares. The output register is
// loaded once it is free. One reading at a time: a new beat is taken only when the sequencer idles.
// Reset (aresetn low, synchronous) empties the output register and idles the sequencer.
module thermistor_resistance_to_temp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [thrt_pkg::S_DATA_W-1:0] s_tdata,   // [17:0] resistance
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [thrt_pkg::M_DATA_W-1:0] m_tdata,   // [13:0] temperature
    output logic [0:0]                    m_tuser    // [0] status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL,
        ST_SUB,
        ST_DONE
    } state_t;

    localparam logic [thrt_pkg::IDX_W-1:0] LAST_IDX = thrt_pkg::IDX_W'(thrt_pkg::TABLE_ENTRIES - 1);
    localparam logic [thrt_pkg::K_W-1:0]   K_LAST   = thrt_pkg::K_W'(thrt_pkg::SUB_STEPS);

    state_t                          state_reg, state_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [thrt_pkg::TEMP_W-1:0]     m_temp_reg, m_temp_next;
    logic                            m_status_reg, m_status_next;

    logic [thrt_pkg::RES_W-1:0]      res_reg, res_next;
    logic [thrt_pkg::IDX_W-1:0]      cur_reg, cur_next;
    logic [thrt_pkg::RES_W-1:0]      rom_q_reg;
    logic [thrt_pkg::RES_W-1:0]      hi_reg, hi_next;
    logic [thrt_pkg::RES_W-1:0]      lo_reg, lo_next;
    logic [thrt_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic [thrt_pkg::RES_W-1:0]      step_reg, step_next;
    logic [thrt_pkg::RES_W-1:0]      point_reg, point_next;
    logic [thrt_pkg::K_W-1:0]        k_reg, k_next;
    logic [thrt_pkg::TEMP_W-1:0]     base_reg, base_next;
    logic [thrt_pkg::TEMP_W-1:0]     temp_reg, temp_next;
    logic                            status_reg, status_next;

    logic [thrt_pkg::RES_W-1:0]      s_res;
    logic [thrt_pkg::RES_W-1:0]      diff;
    logic                            out_free;

    assign s_res    = s_tdata[thrt_pkg::RES_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign diff     = hi_reg - lo_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_temp_next   = m_temp_reg;
        m_status_next = m_status_reg;
        res_next      = res_reg;
        cur_next      = cur_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        prod_next     = prod_reg;
        step_next     = step_reg;
        point_next    = point_reg;
        k_next        = k_reg;
        base_next     = base_reg;
        temp_next     = temp_reg;
        status_next   = status_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_next = s_res;
                    if (s_res >= thrt_pkg::rom_res('0) || s_res <= thrt_pkg::rom_res(LAST_IDX)) begin
                        temp_next   = '0;
                        status_next = 1'b1;
                        state_next  = ST_DONE;
                    end else begin
                        // Entry 1 is read on this edge; entry 0 is the upper bracket.
                        cur_next   = thrt_pkg::IDX_W'(1);
                        hi_next    = thrt_pkg::rom_res('0);
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (rom_q_reg == res_reg) begin
                    temp_next   = thrt_pkg::TEMP_W'(cur_reg) * thrt_pkg::TEMP_W'(thrt_pkg::HUNDREDTHS);
                    status_next = 1'b0;
                    state_next  = ST_DONE;
                end else if (rom_q_reg < res_reg) begin
                    lo_next    = rom_q_reg;
                    base_next  = thrt_pkg::TEMP_W'(cur_reg - thrt_pkg::IDX_W'(1))
                                 * thrt_pkg::TEMP_W'(thrt_pkg::HUNDREDTHS);
                    state_next = ST_MUL;
                end else begin
                    hi_next  = rom_q_reg;
                    cur_next = cur_reg + thrt_pkg::IDX_W'(1);
                end
            end
            ST_MUL: begin
                prod_next  = thrt_pkg::PROD_W'(diff) * thrt_pkg::PROD_W'(thrt_pkg::RECIP);
                state_next = ST_SUB;
                k_next     = '0;
            end
            ST_SUB: begin
                // The first sub-step point is set up on entry, the rest walk down by one step.
                if (k_reg == '0) begin
                    step_next  = thrt_pkg::RES_W'(prod_reg[thrt_pkg::PROD_W-1:thrt_pkg::RECIP_SHIFT]);
                    point_next = hi_reg - thrt_pkg::RES_W'(prod_reg[thrt_pkg::PROD_W-1:thrt_pkg::RECIP_SHIFT]);
                    k_next     = thrt_pkg::K_W'(1);
                end else if (point_reg < res_reg) begin
                    temp_next   = base_reg + thrt_pkg::TEMP_W'(k_reg) * thrt_pkg::TEMP_W'(thrt_pkg::SUB_STEPS);
                    status_next = 1'b0;
                    state_next  = ST_DONE;
                end else if (k_reg == K_LAST) begin
                    // No sub-step point lies below the reading: no increase.
                    temp_next   = base_reg;
                    status_next = 1'b0;
                    state_next  = ST_DONE;
                end else begin
                    point_next = point_reg - step_reg;
                    k_next     = k_reg + thrt_pkg::K_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_temp_next   = temp_reg;
                    m_status_next = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_temp_reg   <= '0;
            m_status_reg <= 1'b0;
            k_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            m_temp_reg   <= m_temp_next;
            m_status_reg <= m_status_next;
            k_reg        <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        rom_q_reg    <= thrt_pkg::rom_res(cur_next);
        res_reg      <= res_next;
        cur_reg      <= cur_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        prod_reg     <= prod_next;
        step_reg     <= step_next;
        point_reg    <= point_next;
        base_reg     <= base_next;
        temp_reg     <= temp_next;
        status_reg   <= status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = thrt_pkg::M_DATA_W'(m_temp_reg);
    assign m_tuser  = m_status_reg;

`ifndef SYNTHESIS
    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("out-of-range result carries a non-zero temperature");

    a_temp_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            m_tdata <= thrt_pkg::M_DATA_W'((thrt_pkg::TABLE_ENTRIES - 1) * thrt_pkg::HUNDREDTHS))
        else $error("converted temperature beyond the table");

    a_walk_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> cur_reg >= thrt_pkg::IDX_W'(1) && cur_reg <= LAST_IDX)
        else $error("table walk left the table");

    a_sub_bracket: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SUB && k_reg != '0 |-> point_reg >= lo_reg && k_reg <= K_LAST)
        else $error("sub-step point fell below the lower bracket");

    a_hold_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg) == ST_DONE && state_reg == ST_DONE |-> $past(m_tvalid) && m_tvalid)
        else $error("finished result held back while the output register was free");
`endif

endmodule

// File: bench/tb.sv
// Self-checking bench for the thermistor resistance to temperature converter.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 1_200_000;
    localparam int RANDOM_READINGS = 2000;
    localparam int DIRECTED_ROWS = 23;
    localparam int LAST = thrt_pkg::TABLE_ENTRIES - 1;

    typedef struct packed {
        logic [thrt_pkg::TEMP_W-1:0] temperature;
        logic                        status;
    } reading_t;

    typedef struct {
        logic [thrt_pkg::RES_W-1:0]  resistance;
        bit                          typed;
        logic [thrt_pkg::TEMP_W-1:0] temperature;
        logic                        status;
    } directed_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [thrt_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [thrt_pkg::M_DATA_W-1:0] m_tdata;
    logic [0:0]                    m_tuser;

    reading_t pending_readings[$];
    bit       failed = 1'b0;
    bit       steady = 1'b0;
    int       cycle_count = 0;

    thermistor_resistance_to_temp uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Interpolated increase, in hundredths of a degree, for a reading strictly between two table entries.
    function automatic int unsigned sub_step_hundredths(input int unsigned hi,
                                                        input int unsigned lo,
                                                        input int unsigned r);
        int unsigned step;
        int unsigned inc;
        bit          hit;
        step = (hi - lo) / thrt_pkg::SUB_STEPS;
        inc  = 0;
        hit  = 1'b0;
        for (int k = 0; k <= thrt_pkg::SUB_STEPS; k++) begin
            if (!hit && (hi - k * step) < r) begin
                inc = k * 10;
                hit = 1'b1;
            end
        end
        return inc;
    endfunction

    function automatic reading_t convert_resistance(input logic [thrt_pkg::RES_W-1:0] r);
        reading_t    res;
        bit          done;
        int unsigned hi;
        int unsigned lo;
        res.temperature = '0;
        res.status      = 1'b1;
        done            = 1'b0;
        if (r > thrt_pkg::ROM_RES[LAST] && r < thrt_pkg::ROM_RES[0]) begin
            for (int i = 1; i < thrt_pkg::TABLE_ENTRIES; i++) begin
                hi = thrt_pkg::ROM_RES[i-1];
                lo = thrt_pkg::ROM_RES[i];
                if (!done && r == lo) begin
                    res.temperature = thrt_pkg::TEMP_W'(thrt_pkg::HUNDREDTHS * i);
                    res.status      = 1'b0;
                    done            = 1'b1;
                end else if (!done && lo < r) begin
                    res.temperature = thrt_pkg::TEMP_W'(thrt_pkg::HUNDREDTHS * (i - 1)
                                                        + sub_step_hundredths(hi, lo, r));
                    res.status      = 1'b0;
                    done            = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Entered just after a rising edge; leaves at the edge where the beat is taken.
    task automatic send_resistance(input logic [thrt_pkg::RES_W-1:0] r,
                                   input reading_t expected);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= thrt_pkg::S_DATA_W'(r);
        do @(posedge aclk); while (!s_tready);
        pending_readings.push_back(expected);
    endtask

    // The input is idled first so that the last beat is not taken a second time.
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [thrt_pkg::RES_W-1:0] random_resistance();
        int unsigned pick;
        int          idx;
        int          k;
        int          val;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            val = $urandom_range(thrt_pkg::ROM_RES[LAST] + 1, thrt_pkg::ROM_RES[0] - 1);
        end else if (pick < 85) begin
            // Around a table entry: exact hits, the ends and the gap below a sub-step grid.
            idx = $urandom_range(0, LAST);
            val = int'(thrt_pkg::ROM_RES[idx]) + $urandom_range(0, 12) - 3;
        end else if (pick < 92) begin
            idx = $urandom_range(1, LAST);
            k   = $urandom_range(0, thrt_pkg::SUB_STEPS);
            val = int'(thrt_pkg::ROM_RES[idx-1])
                  - k * ((int'(thrt_pkg::ROM_RES[idx-1]) - int'(thrt_pkg::ROM_RES[idx]))
                         / thrt_pkg::SUB_STEPS)
                  + $urandom_range(0, 2) - 1;
        end else begin
            val = $urandom_range(0, (1 << thrt_pkg::RES_W) - 1);
        end
        return thrt_pkg::RES_W'(val);
    endfunction

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{18'd0,       1'b1, 14'd0,     1'b1},
        '{18'h3FFFF,   1'b1, 14'd0,     1'b1},
        '{18'd220859,  1'b1, 14'd0,     1'b1},
        '{18'd220860,  1'b1, 14'd0,     1'b1},
        '{18'd12048,   1'b1, 14'd0,     1'b1},
        '{18'd12047,   1'b1, 14'd0,     1'b1},
        '{18'd220186,  1'b1, 14'd100,   1'b0},
        '{18'd122986,  1'b1, 14'd6000,  1'b0},
        '{18'd13170,   1'b1, 14'd11900, 1'b0},
        '{18'd220858,  1'b0, 14'd0,     1'b0},
        '{18'd12049,   1'b0, 14'd0,     1'b0},
        '{18'd220187,  1'b0, 14'd0,     1'b0},
        '{18'd220189,  1'b0, 14'd0,     1'b0},
        '{18'd220190,  1'b0, 14'd0,     1'b0},
        '{18'd220792,  1'b0, 14'd0,     1'b0},
        '{18'd220793,  1'b0, 14'd0,     1'b0},
        '{18'd12050,   1'b0, 14'd0,     1'b0},
        '{18'h2AAAA,   1'b0, 14'd0,     1'b0},
        '{18'h15555,   1'b0, 14'd0,     1'b0},
        '{18'd131072,  1'b0, 14'd0,     1'b0},
        '{18'd131071,  1'b0, 14'd0,     1'b0},
        '{18'd65536,   1'b0, 14'd0,     1'b0},
        '{18'd100000,  1'b0, 14'd0,     1'b0}
    };

    // Stimulus and end of run.
    initial begin
        reading_t                   expected;
        logic [thrt_pkg::RES_W-1:0] r;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[n]) begin
            if (directed_rows[n].typed) begin
                expected.temperature = directed_rows[n].temperature;
                expected.status      = directed_rows[n].status;
            end else begin
                expected = convert_resistance(directed_rows[n].resistance);
            end
            send_resistance(directed_rows[n].resistance, expected);
        end
        wait_for_results();

        for (int n = 0; n < RANDOM_READINGS; n++) begin
            steady = (n >= 600 && n < 800);
            if (n == 1200) begin
                wait_for_results();
            end
            r = random_resistance();
            send_resistance(r, convert_resistance(r));
        end

        wait_for_results();
        repeat (150) @(posedge aclk);
        if (!failed && pending_readings.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Result side: a random stall before each beat, except while steady is set.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 7);
            @(negedge aclk);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        reading_t expected;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                $error("result beat with no reading outstanding: temperature %0d, status %0d",
                       m_tdata[thrt_pkg::TEMP_W-1:0], m_tuser[0]);
                failed = 1'b1;
            end else begin
                expected = pending_readings.pop_front();
                if (m_tdata[thrt_pkg::TEMP_W-1:0] !== expected.temperature) begin
                    $error("temperature: expected %0d, actual %0d",
                           expected.temperature, m_tdata[thrt_pkg::TEMP_W-1:0]);
                    failed = 1'b1;
                end
                if (m_tuser[0] !== expected.status) begin
                    $error("status: expected %0d, actual %0d", expected.status, m_tuser[0]);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

// File: filelist.f
rtl/core/thrt_pkg.sv
rtl/core/thermistor_resistance_to_temp.sv
bench/tb.sv
